// ===== rtl/set_min_gap_and_range_tracker_macros.svh =====
// Assertion macros shared by the set tracker RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef SET_MIN_GAP_AND_RANGE_TRACKER_MACROS_SVH
`define SET_MIN_GAP_AND_RANGE_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define SMGR_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("set tracker check failed");
`define SMGR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("set tracker check failed");
`else
`define SMGR_ASSERT(label, cond)
`define SMGR_ASSERT_IMP(label, ante, cons)
`endif
`endif

// ===== rtl/smgr_pkg.sv =====
// Shared types and constants for the set tracker.
// No dependencies.
package smgr_pkg;

  localparam int VAL_W      = 32;
  localparam int CNT_W      = 11;
  localparam int CAP_W      = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0]        CAP_RESET      = 11'd1024;
  localparam logic [VAL_W-1:0]        GAP_RESET      = 32'hFFFF_FFFF;
  localparam logic signed [VAL_W-1:0] SMALLEST_RESET = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] LARGEST_RESET  = 32'sh8000_0000;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic             done;
    logic             dup;
    logic [VAL_W-1:0] gap;
  } scan_res_t;

endpackage

// ===== rtl/smgr_if.sv =====
// Valid/ready channel interfaces for the input beat and the result beat.
// Depends on smgr_pkg.
interface smgr_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [smgr_pkg::VAL_W-1:0]  new_value;

  modport source (output valid, output new_value, input ready);
  modport sink   (input valid, input new_value, output ready);
endinterface

interface smgr_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [smgr_pkg::CNT_W-1:0]  stored_count;
  logic [smgr_pkg::VAL_W-1:0]  shortest_gap;
  logic [smgr_pkg::VAL_W-1:0]  longest_span;
  logic                        spans_valid;

  modport source (output valid, output status, output stored_count, output shortest_gap,
                  output longest_span, output spans_valid, input ready);
  modport sink   (input valid, input status, input stored_count, input shortest_gap,
                  input longest_span, input spans_valid, output ready);
endinterface

// ===== rtl/smgr_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module smgr_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/smgr_scan.sv =====
// Scan unit: reads each stored entry at most once, stops early on a match and folds
// the smallest distance to the new value. Depends on smgr_pkg and the macros.
`include "set_min_gap_and_range_tracker_macros.svh"
module smgr_scan #(
  parameter int  MAX_ENTRIES = 1024,
  localparam int AW          = $clog2(MAX_ENTRIES),
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [smgr_pkg::VAL_W-1:0]  start_value,
  input  logic [OCC_W-1:0]                   start_count,
  input  logic [smgr_pkg::VAL_W-1:0]         start_gap,
  output logic                               rd_en,
  output logic [AW-1:0]                      rd_addr,
  input  logic [smgr_pkg::VAL_W-1:0]         rd_data,
  output smgr_pkg::scan_res_t                res
);

  localparam int VW = smgr_pkg::VAL_W;

  logic                   busy_r;
  logic                   issuing_r;
  logic                   rd_vld_r;
  logic                   s2_vld_r;
  logic                   done_r;
  logic [OCC_W-1:0]       idx_r;
  logic [OCC_W-1:0]       count_r;
  logic signed [VW-1:0]   val_r;
  logic [VW-1:0]          gap_r;
  logic                   s2_eq_r;
  logic [VW-1:0]          s2_diff_r;
  logic                   dup_r;

  logic [OCC_W-1:0]       idx_nxt;
  logic [VW:0]            fwd;
  logic [VW:0]            rev;
  logic [VW-1:0]          diff;
  logic                   hit;
  logic                   finish;

  always_comb begin
    idx_nxt = idx_r + 1'b1;
    rd_en   = issuing_r;
    rd_addr = idx_r[AW-1:0];
    fwd     = {val_r[VW-1], val_r} - {rd_data[VW-1], rd_data};
    rev     = {rd_data[VW-1], rd_data} - {val_r[VW-1], val_r};
    diff    = fwd[VW] ? rev[VW-1:0] : fwd[VW-1:0];
    hit     = s2_vld_r && s2_eq_r;
    finish  = busy_r && (hit || (!issuing_r && !rd_vld_r && !s2_vld_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      issuing_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      done_r <= finish;
      if (start) begin
        busy_r    <= 1'b1;
        issuing_r <= (start_count != '0);
        rd_vld_r  <= 1'b0;
        s2_vld_r  <= 1'b0;
      end else if (busy_r) begin
        if (hit || finish) begin
          busy_r    <= 1'b0;
          issuing_r <= 1'b0;
          rd_vld_r  <= 1'b0;
          s2_vld_r  <= 1'b0;
        end else begin
          issuing_r <= issuing_r && (idx_nxt != count_r);
          rd_vld_r  <= issuing_r;
          s2_vld_r  <= rd_vld_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r   <= '0;
      count_r <= start_count;
      val_r   <= start_value;
      gap_r   <= start_gap;
      dup_r   <= 1'b0;
    end else begin
      if (issuing_r) begin
        idx_r <= idx_nxt;
      end
      s2_eq_r   <= (rd_data == val_r);
      s2_diff_r <= diff;
      if (hit) begin
        dup_r <= 1'b1;
      end else if (s2_vld_r && (s2_diff_r < gap_r)) begin
        gap_r <= s2_diff_r;
      end
    end
  end

  assign res.done = done_r;
  assign res.dup  = dup_r;
  assign res.gap  = gap_r;

  `SMGR_ASSERT(a_rd_busy, !rd_en || busy_r)
  `SMGR_ASSERT(a_rd_range, !rd_en || (idx_r < count_r))
  `SMGR_ASSERT_IMP(a_start_no_done, start, !done_r && busy_r)

endmodule

// ===== rtl/set_min_gap_and_range_tracker.sv =====
// Top level of the set tracker: control sequencer, statistics, config port.
// Depends on smgr_pkg, smgr_if, smgr_ram, smgr_scan and the macros.
//
//   channel  dir  handshake             payload
//   in_ch    in   valid/ready           new_value
//   out_ch   out  valid/ready           status, stored_count, shortest_gap,
//                                       longest_span, spans_valid
//   cfg_*    in   APB write/read        capacity at byte address 0
//
// For each item the scan reads the value memory once per stored entry through its
// single read port, and stops early on a duplicate. A finished result waits in the
// output register while the next beat is taken; a result still held there stalls
// the next one. Reset needs no memory sweep; only stored entries are read.
`include "set_min_gap_and_range_tracker_macros.svh"
module set_min_gap_and_range_tracker #(
  parameter int  MAX_ENTRIES = 1024,
  localparam int AW          = $clog2(MAX_ENTRIES),
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  smgr_in_if.sink                              in_ch,
  smgr_out_if.source                           out_ch,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [smgr_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [smgr_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [smgr_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int VW    = smgr_pkg::VAL_W;
  localparam int CAP_W = smgr_pkg::CAP_W;
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CAP_W-1:0]         capacity_r;
  logic [OCC_W-1:0]         occ_r;
  logic [VW-1:0]            best_gap_r;
  logic signed [VW-1:0]     smallest_r;
  logic signed [VW-1:0]     largest_r;
  logic signed [VW-1:0]     val_r;
  smgr_pkg::status_t        status_r;

  logic                         out_valid_r;
  logic [1:0]                   out_status_r;
  logic [smgr_pkg::CNT_W-1:0]   out_count_r;
  logic [VW-1:0]                out_gap_r;
  logic [VW-1:0]                out_span_r;
  logic                         out_spans_r;

  logic                     in_fire;
  logic                     cfg_wr;
  logic                     full;
  logic                     ram_we;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [VW-1:0]            ram_rdata;
  logic                     out_load;
  logic                     spans;
  smgr_pkg::scan_res_t      scan_res;

  always_comb begin
    in_fire     = in_ch.valid && in_ch.ready;
    cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == smgr_pkg::REG_CAPACITY);
    full        = (CMP_W'(occ_r) >= CMP_W'(capacity_r)) ||
                  (CMP_W'(occ_r) >= CMP_W'(MAX_ENTRIES));
    ram_we      = (state_r == S_SCAN) && scan_res.done && !scan_res.dup && !full;
    out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
    spans       = (occ_r >= OCC_W'(2));
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.stored_count = out_count_r;
  assign out_ch.shortest_gap = out_gap_r;
  assign out_ch.longest_span = out_span_r;
  assign out_ch.spans_valid  = out_spans_r;
  assign cfg_pready          = 1'b1;
  assign cfg_prdata          = (cfg_paddr[2] == smgr_pkg::REG_CAPACITY) ?
                               smgr_pkg::CFG_DATA_W'(capacity_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      capacity_r  <= smgr_pkg::CAP_RESET;
      occ_r       <= '0;
      best_gap_r  <= smgr_pkg::GAP_RESET;
      smallest_r  <= smgr_pkg::SMALLEST_RESET;
      largest_r   <= smgr_pkg::LARGEST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        capacity_r <= cfg_pwdata[CAP_W-1:0];
      end
      if (ram_we) begin
        occ_r      <= occ_r + 1'b1;
        best_gap_r <= scan_res.gap;
        if (val_r < smallest_r) begin
          smallest_r <= val_r;
        end
        if (val_r > largest_r) begin
          largest_r <= val_r;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      val_r <= in_ch.new_value;
    end
    if ((state_r == S_SCAN) && scan_res.done) begin
      priority if (scan_res.dup) begin
        status_r <= smgr_pkg::ST_DUPLICATE;
      end else if (full) begin
        status_r <= smgr_pkg::ST_FULL;
      end else begin
        status_r <= smgr_pkg::ST_INSERTED;
      end
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_count_r  <= smgr_pkg::CNT_W'(occ_r);
      out_gap_r    <= spans ? best_gap_r : smgr_pkg::GAP_RESET;
      out_span_r   <= spans ? VW'(largest_r - smallest_r) : '0;
      out_spans_r  <= spans;
    end
  end

  smgr_scan #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_fire),
    .start_value (in_ch.new_value),
    .start_count (occ_r),
    .start_gap   (best_gap_r),
    .rd_en       (ram_re),
    .rd_addr     (ram_raddr),
    .rd_data     (ram_rdata),
    .res         (scan_res)
  );

  smgr_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (occ_r[AW-1:0]),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `SMGR_ASSERT(a_we_scan, !ram_we || ((state_r == S_SCAN) && scan_res.done))
  `SMGR_ASSERT_IMP(a_occ_step, ram_we, occ_r == ($past(occ_r) + 1'b1))
  `SMGR_ASSERT_IMP(a_accept_scan, in_fire, (state_r == S_SCAN) && !in_ch.ready)

endmodule
